FILE: design/hete_pkg.sv
// Shared types, codes and microcode table for the HTML escape / tab expander.
`timescale 1ns / 1ps
`default_nettype none
package hete_pkg;

  localparam int MAX_TAB_WIDTH_DEF = 32;
  localparam int RESULT_CAP        = 32;
  localparam int PHASE_W           = 5;
  localparam int TAB_W             = 6;
  localparam int UPC_W             = 6;
  localparam int NLC_W             = 16;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_NBSP     = 2'd1;
  localparam logic [1:0] KIND_SELFTERM = 2'd2;

  // input modes
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_VISIBLE = 2'd1;
  localparam logic [1:0] MODE_PRE     = 2'd2;

  // register indexes
  localparam logic [1:0] REG_TAB_WIDTH  = 2'd0;
  localparam logic [1:0] REG_COPYRIGHT  = 2'd1;
  localparam logic [1:0] REG_REGISTERED = 2'd2;

  localparam logic [TAB_W-1:0] TAB_WIDTH_RST  = 6'd5;
  localparam logic [7:0]       COPYRIGHT_RST  = 8'd169;
  localparam logic [7:0]       REGISTERED_RST = 8'd174;

  // character codes
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  // microprogram entry points
  localparam logic [UPC_W-1:0] UA_LT   = 6'd0;
  localparam logic [UPC_W-1:0] UA_GT   = 6'd4;
  localparam logic [UPC_W-1:0] UA_AMP  = 6'd8;
  localparam logic [UPC_W-1:0] UA_QUOT = 6'd13;
  localparam logic [UPC_W-1:0] UA_REG  = 6'd19;
  localparam logic [UPC_W-1:0] UA_COPY = 6'd25;
  localparam logic [UPC_W-1:0] UA_CHR  = 6'd31;
  localparam logic [UPC_W-1:0] UA_NBSP = 6'd32;
  localparam logic [UPC_W-1:0] UA_TABN = 6'd33;
  localparam logic [UPC_W-1:0] UA_TABS = 6'd34;
  localparam logic [UPC_W-1:0] UA_BR   = 6'd35;

  typedef struct packed {
    logic [7:0] char_in;
    logic [1:0] mode;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       kind;
    logic             last;
    logic [NLC_W-1:0] newlines_since_text;
  } out_beat_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               line_start;
    logic [NLC_W-1:0]   nl_count;
  } line_state_t;

  // decoder -> sequencer launch
  typedef struct packed {
    logic             go;
    logic [UPC_W-1:0] upc;
    logic [TAB_W-1:0] cnt;
    logic [7:0]       chr;
  } launch_t;

  typedef enum logic [2:0] {
    SRC_LIT      = 3'd0,
    SRC_CHR      = 3'd1,
    SRC_SP       = 3'd2,
    SRC_NBSP     = 3'd3,
    SRC_SELFTERM = 3'd4
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] lit;
    logic       fin;  // last word of the program
    logic       rep;  // repeat until the count reaches one
  } ucode_t;

  function automatic ucode_t uc_word(input src_t s, input logic [7:0] l,
                                     input logic f, input logic r);
    ucode_t w;
    w.src = s;
    w.lit = l;
    w.fin = f;
    w.rep = r;
    return w;
  endfunction

  function automatic ucode_t uc_rom(input logic [UPC_W-1:0] a);
    ucode_t w;
    case (a)
      6'd0:  w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd1:  w = uc_word(SRC_LIT, "l", 1'b0, 1'b0);
      6'd2:  w = uc_word(SRC_LIT, "t", 1'b0, 1'b0);
      6'd3:  w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd4:  w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd5:  w = uc_word(SRC_LIT, "g", 1'b0, 1'b0);
      6'd6:  w = uc_word(SRC_LIT, "t", 1'b0, 1'b0);
      6'd7:  w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd8:  w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd9:  w = uc_word(SRC_LIT, "a", 1'b0, 1'b0);
      6'd10: w = uc_word(SRC_LIT, "m", 1'b0, 1'b0);
      6'd11: w = uc_word(SRC_LIT, "p", 1'b0, 1'b0);
      6'd12: w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd13: w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd14: w = uc_word(SRC_LIT, "q", 1'b0, 1'b0);
      6'd15: w = uc_word(SRC_LIT, "u", 1'b0, 1'b0);
      6'd16: w = uc_word(SRC_LIT, "o", 1'b0, 1'b0);
      6'd17: w = uc_word(SRC_LIT, "t", 1'b0, 1'b0);
      6'd18: w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd19: w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd20: w = uc_word(SRC_LIT, "#", 1'b0, 1'b0);
      6'd21: w = uc_word(SRC_LIT, "1", 1'b0, 1'b0);
      6'd22: w = uc_word(SRC_LIT, "7", 1'b0, 1'b0);
      6'd23: w = uc_word(SRC_LIT, "4", 1'b0, 1'b0);
      6'd24: w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd25: w = uc_word(SRC_LIT, "&", 1'b0, 1'b0);
      6'd26: w = uc_word(SRC_LIT, "#", 1'b0, 1'b0);
      6'd27: w = uc_word(SRC_LIT, "1", 1'b0, 1'b0);
      6'd28: w = uc_word(SRC_LIT, "6", 1'b0, 1'b0);
      6'd29: w = uc_word(SRC_LIT, "9", 1'b0, 1'b0);
      6'd30: w = uc_word(SRC_LIT, ";", 1'b1, 1'b0);
      6'd31: w = uc_word(SRC_CHR, 8'h00, 1'b1, 1'b0);
      6'd32: w = uc_word(SRC_NBSP, 8'h00, 1'b1, 1'b0);
      6'd33: w = uc_word(SRC_NBSP, 8'h00, 1'b1, 1'b1);
      6'd34: w = uc_word(SRC_SP, 8'h00, 1'b1, 1'b1);
      6'd35: w = uc_word(SRC_LIT, "<", 1'b0, 1'b0);
      6'd36: w = uc_word(SRC_LIT, "b", 1'b0, 1'b0);
      6'd37: w = uc_word(SRC_LIT, "r", 1'b0, 1'b0);
      6'd38: w = uc_word(SRC_SELFTERM, 8'h00, 1'b0, 1'b0);
      6'd39: w = uc_word(SRC_LIT, CH_LF, 1'b1, 1'b0);
      default: w = uc_word(SRC_LIT, 8'h00, 1'b1, 1'b0);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/hete_decode.sv
// Entry-point decoder: picks the microprogram and the next line state for one character.
`timescale 1ns / 1ps
`default_nettype none
module hete_decode
  import hete_pkg::*;
(
  input  in_beat_t         beat,
  input  line_state_t      cur,
  input  logic [TAB_W-1:0] eff_tab,
  input  logic [7:0]       copyright_code,
  input  logic [7:0]       registered_code,
  output launch_t          launch,
  output line_state_t      nxt
);

  logic [7:0]         c;
  logic               ws;
  logic [TAB_W-1:0]   ph_inc;
  logic [PHASE_W-1:0] adv_phase;
  logic [TAB_W-1:0]   ntab;
  logic [NLC_W-1:0]   nl_inc;
  logic               is_ent;

  assign c         = beat.char_in;
  assign ws        = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  assign ph_inc    = {1'b0, cur.phase} + TAB_W'(1);
  assign adv_phase = (ph_inc == eff_tab) ? '0 : ph_inc[PHASE_W-1:0];
  assign ntab      = eff_tab - {1'b0, cur.phase};
  assign nl_inc    = (cur.nl_count == '1) ? cur.nl_count : cur.nl_count + NLC_W'(1);
  assign is_ent    = (c == CH_LT) || (c == CH_GT) || (c == CH_AMP) || (c == CH_QUOT) ||
                     (c == registered_code) || (c == copyright_code);

  always_comb begin
    launch.go  = 1'b1;
    launch.upc = UA_CHR;
    launch.cnt = ntab;
    launch.chr = c;
    nxt        = cur;
    if (is_ent) begin
      if (c == CH_LT) begin
        launch.upc = UA_LT;
      end else if (c == CH_GT) begin
        launch.upc = UA_GT;
      end else if (c == CH_AMP) begin
        launch.upc = UA_AMP;
      end else if (c == CH_QUOT) begin
        launch.upc = UA_QUOT;
      end else if (c == registered_code) begin
        launch.upc = UA_REG;
      end else begin
        launch.upc = UA_COPY;
      end
    end else begin
      case (beat.mode)
        MODE_VISIBLE: begin
          if (c == CH_SP) begin
            launch.upc     = UA_NBSP;
            nxt.phase      = adv_phase;
            nxt.line_start = 1'b0;
          end else if (c == CH_TAB) begin
            launch.upc     = UA_TABN;
            nxt.phase      = '0;
            nxt.line_start = 1'b0;
          end else if (c == CH_LF) begin
            launch.upc     = UA_BR;
            nxt.phase      = '0;
            nxt.line_start = 1'b1;
            nxt.nl_count   = nl_inc;
          end else begin
            nxt.phase      = adv_phase;
            nxt.line_start = 1'b0;
          end
        end
        MODE_PRE: begin
          if (c == CH_TAB) begin
            launch.upc     = UA_TABS;
            nxt.phase      = '0;
            nxt.line_start = 1'b0;
          end else if (c == CH_LF) begin
            nxt.phase      = '0;
            nxt.line_start = 1'b1;
            nxt.nl_count   = nl_inc;
          end else begin
            nxt.phase      = adv_phase;
            nxt.line_start = 1'b0;
          end
        end
        default: begin
          // plain text: drop whitespace at line start
          if (!cur.line_start || !ws) begin
            nxt.phase      = adv_phase;
            nxt.line_start = 1'b0;
          end else begin
            launch.go = 1'b0;
          end
        end
      endcase
      if (!ws) begin
        nxt.nl_count = '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/hete_useq.sv
// Microcode sequencer: steps the control ROM and registers one result beat per cycle while res_ready does not stall it.
`timescale 1ns / 1ps
`default_nettype none
module hete_useq
  import hete_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  launch_t          launch,
  input  logic [NLC_W-1:0] nl_count,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output out_beat_t        res
);

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [TAB_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       chr_r, chr_nxt;
  logic             vld_r, vld_nxt;
  out_beat_t        res_r, res_nxt;
  ucode_t           uw;
  logic             step;
  logic             hold;

  assign uw    = uc_rom(upc_r);
  assign step  = busy_r && (!vld_r || res_ready);
  assign hold  = uw.rep && (cnt_r != TAB_W'(1));
  assign idle  = !busy_r;
  assign res_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    cnt_nxt  = cnt_r;
    chr_nxt  = chr_r;
    vld_nxt  = vld_r && !res_ready;
    res_nxt  = res_r;
    if (step) begin
      vld_nxt = 1'b1;
      res_nxt.newlines_since_text = nl_count;
      res_nxt.last = uw.fin && !hold;
      case (uw.src)
        SRC_LIT: begin
          res_nxt.out_byte = uw.lit;
          res_nxt.kind     = KIND_BYTE;
        end
        SRC_CHR: begin
          res_nxt.out_byte = chr_r;
          res_nxt.kind     = KIND_BYTE;
        end
        SRC_SP: begin
          res_nxt.out_byte = CH_SP;
          res_nxt.kind     = KIND_BYTE;
        end
        SRC_NBSP: begin
          res_nxt.out_byte = 8'h00;
          res_nxt.kind     = KIND_NBSP;
        end
        default: begin
          res_nxt.out_byte = 8'h00;
          res_nxt.kind     = KIND_SELFTERM;
        end
      endcase
      if (hold) begin
        cnt_nxt = cnt_r - TAB_W'(1);
      end else if (uw.fin) begin
        busy_nxt = 1'b0;
      end else begin
        upc_nxt = upc_r + UPC_W'(1);
      end
    end
    if (launch.go) begin
      busy_nxt = 1'b1;
      upc_nxt  = launch.upc;
      cnt_nxt  = launch.cnt;
      chr_nxt  = launch.chr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
    upc_r <= upc_nxt;
    cnt_r <= cnt_nxt;
    chr_r <= chr_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: design/html_escape_tab_expander.sv
// Top level of the HTML entity escaper with tab expansion.
// An accepted item is latched into the sequencer; each result beat is then registered.
// The sequencer accepts no new item until it has issued every result beat of the current
// one (entities 4 to 6 beats, tabs up to 32); a dropped item yields no result beats.
// Reset: synchronous, active low; tab width 5, codes 169/174, column 0, line start set.
`timescale 1ns / 1ps
`default_nettype none
module html_escape_tab_expander
  import hete_pkg::*;
#(
  parameter int MAX_TAB_WIDTH = MAX_TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Tab stops never exceed the result cap, whatever the parameter says.
  localparam int TAB_CAP = (MAX_TAB_WIDTH > RESULT_CAP) ? RESULT_CAP : MAX_TAB_WIDTH;

  logic [TAB_W-1:0] tab_width_r;
  logic [7:0]       copyright_r;
  logic [7:0]       registered_r;
  line_state_t      line_r, line_nxt;
  line_state_t      dec_state;
  launch_t          dec_launch;
  launch_t          launch;
  logic [TAB_W-1:0] eff_tab;
  logic             in_fire;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             seq_idle;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign in_ready = seq_idle;
  assign in_fire  = in_valid && in_ready;

  // Clamp the written tab width into 1..TAB_CAP.
  assign eff_tab = (tab_width_r == '0) ? TAB_W'(1) :
                   (tab_width_r > TAB_W'(TAB_CAP)) ? TAB_W'(TAB_CAP) : tab_width_r;

  // Read back the raw register values.
  always_comb begin
    unique case (reg_idx)
      REG_TAB_WIDTH:  prdata = {26'd0, tab_width_r};
      REG_COPYRIGHT:  prdata = {24'd0, copyright_r};
      REG_REGISTERED: prdata = {24'd0, registered_r};
      default:        prdata = '0;
    endcase
  end

  // Decode the incoming character against the current line state.
  hete_decode u_decode (
    .beat            (in_data),
    .cur             (line_r),
    .eff_tab         (eff_tab),
    .copyright_code  (copyright_r),
    .registered_code (registered_r),
    .launch          (dec_launch),
    .nxt             (dec_state)
  );

  // Launch the microprogram only on an accepted beat that yields results.
  always_comb begin
    launch    = dec_launch;
    launch.go = dec_launch.go && in_fire;
  end

  // Advance the line state at accept; a tab width write restarts the column.
  always_comb begin
    line_nxt = line_r;
    if (cfg_wr && (reg_idx == REG_TAB_WIDTH)) begin
      line_nxt.phase      = '0;
      line_nxt.line_start = 1'b1;
    end else if (in_fire) begin
      line_nxt = dec_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r         <= TAB_WIDTH_RST;
      copyright_r         <= COPYRIGHT_RST;
      registered_r        <= REGISTERED_RST;
      line_r.phase        <= '0;
      line_r.line_start   <= 1'b1;
      line_r.nl_count     <= '0;
    end else begin
      line_r <= line_nxt;
      if (cfg_wr) begin
        case (reg_idx)
          REG_TAB_WIDTH:  tab_width_r  <= pwdata[TAB_W-1:0];
          REG_COPYRIGHT:  copyright_r  <= pwdata[7:0];
          REG_REGISTERED: registered_r <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Sequencer holds the newline count of the line state, already updated at accept.
  hete_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .launch    (launch),
    .nl_count  (line_r.nl_count),
    .idle      (seq_idle),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (out_data)
  );

`ifndef SYNTHESIS
  // Column phase stays below the effective tab width.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, line_r.phase} < eff_tab)
    else $error("column phase out of range");

  // Newline count only steps up by one or clears.
  a_nl_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (line_r.nl_count != $past(line_r.nl_count))) |->
      ((line_r.nl_count == '0) || (line_r.nl_count == $past(line_r.nl_count) + NLC_W'(1))))
    else $error("newline count jumped");

  // Token beats carry a zero byte.
  a_token_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind != KIND_BYTE)) |-> (out_data.out_byte == 8'h00))
    else $error("token beat with nonzero byte");
`endif

endmodule
`default_nettype wire
